>>> design/dci_pkg.sv
// Diode curve interpolator package: calibration ROM, widths, lookup helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dci_pkg;

    localparam int ROM_POINTS      = 75;
    localparam int CURVE_POINTS_DEF = 75;

    localparam int V_W    = 21;  // microvolts
    localparam int T_W    = 19;  // millikelvin
    localparam int SEG_W  = 7;
    localparam int DT_W   = 16;  // largest temperature step between points
    localparam int SPAN_W = 17;  // largest voltage step between points
    localparam int PROD_W = DT_W + SPAN_W;
    localparam int Q_W    = 16;  // quotient < dt

    localparam logic [V_W-1:0] CURVE_UV [ROM_POINTS] = '{
        21'd90570,   21'd110239,  21'd136555,  21'd179181,  21'd265393,
        21'd349522,  21'd452797,  21'd513393,  21'd563128,  21'd607845,
        21'd648723,  21'd686936,  21'd722511,  21'd755487,  21'd786992,
        21'd817025,  21'd844538,  21'd869583,  21'd893230,  21'd914469,
        21'd934356,  21'd952903,  21'd970134,  21'd986073,  21'd998925,
        21'd1010640, 21'd1021250, 21'd1031670, 21'd1041890, 21'd1051920,
        21'd1062770, 21'd1074720, 21'd1091100, 21'd1096020, 21'd1100140,
        21'd1103930, 21'd1107020, 21'd1109740, 21'd1112040, 21'd1114140,
        21'd1116280, 21'd1118530, 21'd1120900, 21'd1123400, 21'd1125890,
        21'd1129130, 21'd1134940, 21'd1144950, 21'd1162970, 21'd1176510,
        21'd1194750, 21'd1242080, 21'd1261220, 21'd1278110, 21'd1294300,
        21'd1310700, 21'd1327270, 21'd1345060, 21'd1364230, 21'd1383610,
        21'd1404540, 21'd1427320, 21'd1452060, 21'd1485780, 21'd1535230,
        21'd1566840, 21'd1583580, 21'd1596900, 21'd1607560, 21'd1621250,
        21'd1629450, 21'd1635160, 21'd1639430, 21'd1642610, 21'd1644300
    };

    localparam logic [T_W-1:0] CURVE_MK [ROM_POINTS] = '{
        19'd500000, 19'd491000, 19'd479500, 19'd461500, 19'd425500,
        19'd390000, 19'd346000, 19'd320000, 19'd298500, 19'd279000,
        19'd261000, 19'd244000, 19'd228000, 19'd213000, 19'd198500,
        19'd184500, 19'd171500, 19'd159500, 19'd148000, 19'd137500,
        19'd127500, 19'd118000, 19'd109000, 19'd100500, 19'd93500,
        19'd87000,  19'd81000,  19'd75000,  19'd69000,  19'd63000,
        19'd56400,  19'd49000,  19'd38700,  19'd35700,  19'd33300,
        19'd31200,  19'd29600,  19'd28300,  19'd27300,  19'd26500,
        19'd25800,  19'd25200,  19'd24700,  19'd24300,  19'd24000,
        19'd23700,  19'd23300,  19'd22800,  19'd22000,  19'd21300,
        19'd20200,  19'd17100,  19'd15900,  19'd14900,  19'd14000,
        19'd13150,  19'd12350,  19'd11550,  19'd10750,  19'd10000,
        19'd9250,   19'd8500,   19'd7750,   19'd6800,   19'd5460,
        19'd4560,   19'd4040,   19'd3580,   19'd3180,   19'd2620,
        19'd2260,   19'd1980,   19'd1740,   19'd1530,   19'd1400
    };

    // Indexes past the ROM read as zero.
    function automatic logic [V_W-1:0] rom_uv(input logic [SEG_W-1:0] idx);
        logic [V_W-1:0] r;
        r = '0;
        for (int k = 0; k < ROM_POINTS; k++)
        begin
            if (idx == SEG_W'(k))
            begin
                r = CURVE_UV[k];
            end
        end
        return r;
    endfunction

    function automatic logic [T_W-1:0] rom_mk(input logic [SEG_W-1:0] idx);
        logic [T_W-1:0] r;
        r = '0;
        for (int k = 0; k < ROM_POINTS; k++)
        begin
            if (idx == SEG_W'(k))
            begin
                r = CURVE_MK[k];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/diode_curve_interpolator.sv
// Diode curve interpolator top level: compare, lookup, multiply, divide pipeline.
// Depends on dci_pkg (calibration ROM and widths).
`timescale 1ns / 1ps
`default_nettype none

// Converts a diode voltage (uV) to temperature (mK) over the calibration curve.
// Fully pipelined: one transfer accepted per cycle while in_stall is low. Stage 1
// compares the sample against every curve point, stage 2 counts points below it
// (segment index), stage 3 reads the ROM and forms the differences, stage 4
// multiplies, then 16 restoring-division stages produce one quotient bit each,
// and a final stage adds T[i]. The whole pipe advances together; in_stall rises
// only when a finished result waits on out_stall. Samples at or below V[0] or
// above the last point give in_range 0, temp_mk 0 and segment 0.
module diode_curve_interpolator #(
    parameter int CURVE_POINTS = dci_pkg::CURVE_POINTS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [dci_pkg::V_W-1:0]      voltage_uv,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [dci_pkg::T_W-1:0]      temp_mk,
    output logic                         in_range,
    output logic [dci_pkg::SEG_W-1:0]    segment
);

    localparam int NPTS = (CURVE_POINTS < dci_pkg::ROM_POINTS) ?
                          CURVE_POINTS : dci_pkg::ROM_POINTS;
    localparam int NDIV = dci_pkg::Q_W;

    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // stage 1: thermometer of points below the sample
    logic                          s1_valid_reg;
    logic [dci_pkg::V_W-1:0]       s1_v_reg;
    logic [dci_pkg::ROM_POINTS-1:0] s1_gt_reg;
    logic [dci_pkg::ROM_POINTS-1:0] s1_gt_next;

    always_comb
    begin
        for (int k = 0; k < dci_pkg::ROM_POINTS; k++)
        begin
            s1_gt_next[k] = (voltage_uv > dci_pkg::CURVE_UV[k]);
        end
    end

    // stage 2: segment index
    logic                          s2_valid_reg;
    logic [dci_pkg::V_W-1:0]       s2_v_reg;
    logic [dci_pkg::SEG_W-1:0]     s2_seg_reg;
    logic                          s2_inr_reg;
    logic [dci_pkg::SEG_W-1:0]     s2_cnt_next;

    assign s2_cnt_next = dci_pkg::SEG_W'($countones(s1_gt_reg));

    // stage 3: ROM read and differences
    logic                          s3_valid_reg;
    logic [dci_pkg::DT_W-1:0]      s3_dt_reg;
    logic [dci_pkg::SPAN_W-1:0]    s3_diff_reg;
    logic [dci_pkg::SPAN_W-1:0]    s3_span_reg;
    logic [dci_pkg::T_W-1:0]       s3_thi_reg;
    logic [dci_pkg::SEG_W-1:0]     s3_seg_reg;
    logic                          s3_inr_reg;

    logic [dci_pkg::V_W-1:0] vhi, vlo;
    logic [dci_pkg::T_W-1:0] thi, tlo;
    assign vhi = dci_pkg::rom_uv(s2_seg_reg);
    assign vlo = dci_pkg::rom_uv(s2_seg_reg - 1'b1);
    assign thi = dci_pkg::rom_mk(s2_seg_reg);
    assign tlo = dci_pkg::rom_mk(s2_seg_reg - 1'b1);

    // stage 4: product feeds the divider
    logic [dci_pkg::PROD_W-1:0]    prod_next;
    assign prod_next = (s3_span_reg == '0) ? '0 :
                       dci_pkg::PROD_W'(s3_dt_reg) * dci_pkg::PROD_W'(s3_diff_reg);

    // divider stages 0..NDIV; stage 0 is loaded from the product
    logic                          d_valid_reg [NDIV+1];
    logic [dci_pkg::SPAN_W-1:0]    d_rem_reg   [NDIV+1];
    logic [NDIV-1:0]               d_low_reg   [NDIV+1];
    logic [dci_pkg::Q_W-1:0]       d_q_reg     [NDIV+1];
    logic [dci_pkg::SPAN_W-1:0]    d_span_reg  [NDIV+1];
    logic [dci_pkg::T_W-1:0]       d_thi_reg   [NDIV+1];
    logic [dci_pkg::SEG_W-1:0]     d_seg_reg   [NDIV+1];
    logic                          d_inr_reg   [NDIV+1];

    logic [dci_pkg::SPAN_W:0]      d_trial [NDIV];
    logic                          d_bit   [NDIV];

    always_comb
    begin
        for (int k = 0; k < NDIV; k++)
        begin
            d_trial[k] = {d_rem_reg[k], d_low_reg[k][NDIV-1]};
            d_bit[k]   = (d_trial[k] >= {1'b0, d_span_reg[k]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
            for (int k = 0; k <= NDIV; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            d_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k <= NDIV; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
            out_valid <= d_valid_reg[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_v_reg  <= voltage_uv;
            s1_gt_reg <= s1_gt_next;

            s2_v_reg   <= s1_v_reg;
            s2_inr_reg <= (s2_cnt_next != '0) && (s2_cnt_next < dci_pkg::SEG_W'(NPTS));
            s2_seg_reg <= ((s2_cnt_next != '0) && (s2_cnt_next < dci_pkg::SEG_W'(NPTS))) ?
                          s2_cnt_next : '0;

            // out of range: zero step and base so the result comes out zero
            s3_inr_reg  <= s2_inr_reg;
            s3_seg_reg  <= s2_seg_reg;
            s3_thi_reg  <= s2_inr_reg ? thi : '0;
            s3_dt_reg   <= (s2_inr_reg && tlo >= thi) ? dci_pkg::DT_W'(tlo - thi) : '0;
            s3_diff_reg <= dci_pkg::SPAN_W'(vhi - s2_v_reg);
            s3_span_reg <= dci_pkg::SPAN_W'(vhi - vlo);

            // quotient is below 2^16, so the top bits are already below span
            d_rem_reg[0]  <= prod_next[dci_pkg::PROD_W-1:NDIV];
            d_low_reg[0]  <= prod_next[NDIV-1:0];
            d_q_reg[0]    <= '0;
            d_span_reg[0] <= s3_span_reg;
            d_thi_reg[0]  <= s3_thi_reg;
            d_seg_reg[0]  <= s3_seg_reg;
            d_inr_reg[0]  <= s3_inr_reg;

            for (int k = 1; k <= NDIV; k++)
            begin
                d_rem_reg[k]  <= d_bit[k-1] ?
                                 dci_pkg::SPAN_W'(d_trial[k-1] - {1'b0, d_span_reg[k-1]}) :
                                 dci_pkg::SPAN_W'(d_trial[k-1]);
                d_low_reg[k]  <= {d_low_reg[k-1][NDIV-2:0], 1'b0};
                d_q_reg[k]    <= {d_q_reg[k-1][dci_pkg::Q_W-2:0], d_bit[k-1]};
                d_span_reg[k] <= d_span_reg[k-1];
                d_thi_reg[k]  <= d_thi_reg[k-1];
                d_seg_reg[k]  <= d_seg_reg[k-1];
                d_inr_reg[k]  <= d_inr_reg[k-1];
            end

            temp_mk  <= d_thi_reg[NDIV] + dci_pkg::T_W'(d_q_reg[NDIV]);
            in_range <= d_inr_reg[NDIV];
            segment  <= d_seg_reg[NDIV];
        end
    end

    // out-of-range results carry zero temperature and segment
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_range) |-> (temp_mk == '0 && segment == '0))
        else $error("out-of-range result not zeroed");

    // in-range segment lies inside the curve
    a_seg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_range) |->
        (segment != '0 && segment < dci_pkg::SEG_W'(NPTS)))
        else $error("segment outside curve");

    // input back-pressure only from a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

>>> tb/diode_curve_interpolator_test.sv
// Testbench for diode_curve_interpolator: directed and random voltage samples,
// predicted by a local curve interpolation and checked in order by a scoreboard.
// Depends on the design top level (which uses dci_pkg); widths are written out here.
`timescale 1ns / 1ps

class curve_scoreboard;
    // Own copy of the calibration curve.
    int unsigned pt_uv[75] = '{
        90570, 110239, 136555, 179181, 265393, 349522, 452797, 513393,
        563128, 607845, 648723, 686936, 722511, 755487, 786992, 817025,
        844538, 869583, 893230, 914469, 934356, 952903, 970134, 986073,
        998925, 1010640, 1021250, 1031670, 1041890, 1051920, 1062770, 1074720,
        1091100, 1096020, 1100140, 1103930, 1107020, 1109740, 1112040, 1114140,
        1116280, 1118530, 1120900, 1123400, 1125890, 1129130, 1134940, 1144950,
        1162970, 1176510, 1194750, 1242080, 1261220, 1278110, 1294300, 1310700,
        1327270, 1345060, 1364230, 1383610, 1404540, 1427320, 1452060, 1485780,
        1535230, 1566840, 1583580, 1596900, 1607560, 1621250, 1629450, 1635160,
        1639430, 1642610, 1644300};
    int unsigned pt_mk[75] = '{
        500000, 491000, 479500, 461500, 425500, 390000, 346000, 320000,
        298500, 279000, 261000, 244000, 228000, 213000, 198500,
        184500, 171500, 159500, 148000, 137500, 127500, 118000, 109000, 100500,
        93500, 87000, 81000, 75000, 69000, 63000, 56400, 49000,
        38700, 35700, 33300, 31200, 29600, 28300, 27300, 26500,
        25800, 25200, 24700, 24300, 24000, 23700, 23300, 22800,
        22000, 21300, 20200, 17100, 15900, 14900, 14000, 13150,
        12350, 11550, 10750, 10000, 9250, 8500, 7750, 6800,
        5460, 4560, 4040, 3580, 3180, 2620, 2260, 1980,
        1740, 1530, 1400};
    logic [26:0] pending_temps[$];   // {temp, in_range, segment}
    int errors = 0;

    function void note_sample(logic [20:0] v);
        logic [63:0] frac;
        logic [18:0] t;
        logic        r;
        logic [6:0]  s;
        t = '0; r = 1'b0; s = '0;
        for (int i = 1; i < 75; i++)
        begin
            if (v > pt_uv[i-1] && v <= pt_uv[i])
            begin
                frac = 64'(pt_mk[i-1] - pt_mk[i]) * 64'(pt_uv[i] - v)
                       / 64'(pt_uv[i] - pt_uv[i-1]);
                t = 19'(pt_mk[i] + frac);
                r = 1'b1;
                s = 7'(i);
                break;
            end
        end
        pending_temps.push_back({t, r, s});
    endfunction

    function void check_result(logic [18:0] t, logic r, logic [6:0] s);
        logic [26:0] e;
        if (pending_temps.size() == 0)
        begin
            $error("unexpected result temp_mk=%0d", t);
            errors++;
            return;
        end
        e = pending_temps.pop_front();
        if (e[26:8] !== t)
        begin
            $error("temp_mk expected %0d actual %0d", e[26:8], t);
            errors++;
        end
        if (e[7] !== r)
        begin
            $error("in_range expected %0d actual %0d", e[7], r);
            errors++;
        end
        if (e[6:0] !== s)
        begin
            $error("segment expected %0d actual %0d", e[6:0], s);
            errors++;
        end
    endfunction
endclass

module diode_curve_interpolator_test;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [20:0] voltage_uv = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [18:0] temp_mk;
    logic        in_range;
    logic [6:0]  segment;

    int send_idle_pct = 0;   // chance in a hundred the sender idles a cycle
    int recv_stall_pct = 0;  // chance in a hundred the receiver stalls
    longint cycles = 0;
    curve_scoreboard sb = new();

    diode_curve_interpolator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .voltage_uv(voltage_uv),
        .out_valid(out_valid), .out_stall(out_stall),
        .temp_mk(temp_mk), .in_range(in_range), .segment(segment)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: far above the slowest correct run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check at the rising edge, pick the next stall at the falling.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(temp_mk, in_range, segment);
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One sample transfer, with random idle cycles ahead of it.
    // in_valid stays high after the transfer; idle cycles or the drain drop it.
    task automatic send_sample(logic [20:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        voltage_uv <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_sample(v);
        @(negedge clk);
    endtask

    // Random sample: mostly inside the curve, near breakpoints, sometimes anywhere.
    function automatic logic [20:0] pick_sample();
        int k;
        k = $urandom_range(99);
        if (k < 15)
        begin
            return 21'($urandom);
        end
        else if (k < 40)
        begin
            return 21'(sb.pt_uv[$urandom_range(74)] + $urandom_range(2) - 1);
        end
        return 21'($urandom_range(1644300, 90571));
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_temps.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, curve ends, breakpoint edges, mid-segment.
        send_sample(21'd0);
        send_sample(21'h1FFFFF);
        send_sample(21'd90570);
        send_sample(21'd90571);
        send_sample(21'd110239);
        send_sample(21'd110240);
        send_sample(21'd1644299);
        send_sample(21'd1644300);
        send_sample(21'd1644301);
        send_sample(21'd1091100);
        send_sample(21'd1091101);
        send_sample(21'd1200000);
        send_sample(21'd700000);
        send_sample(21'h0AAAAA);
        send_sample(21'h155555);
        // Pause until every result is back.
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 210; n++)
            begin
                send_sample(pick_sample());
            end
        end

        wait_drained();
        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
